/* src/dae_pkg.sv */
// ----------------------------------------------------------------------------
// dae_pkg
// Shared types and constants for the congestion alpha estimator: request
// codes, register indexes, field widths and divider sizing.
// ----------------------------------------------------------------------------
package dae_pkg;

    localparam int SEQ_W    = 32;
    localparam int CWND_W   = 20;
    localparam int ALPHA_W  = 11;
    localparam int GAIN_W   = 4;
    localparam int MSS_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 11'd1024;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = 4'd10;

    // divider: marked bytes shifted by up to ten over the byte total
    localparam int DVD_W     = SEQ_W + 10;
    localparam int DVS_W     = SEQ_W;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    typedef enum logic [2:0] {
        REQ_START     = 3'd0,
        REQ_ACK       = 3'd1,
        REQ_LOSS_CUT  = 3'd2,
        REQ_ENTER_LOSS = 3'd3,
        REQ_UNDO      = 3'd4
    } req_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_SHIFT    = 2'd0,
        CFG_INITIAL_ALPHA = 2'd1,
        CFG_CLAMP_ON_LOSS = 2'd2,
        CFG_MSS_BYTES     = 2'd3
    } cfg_index_t;

    // saturating 32-bit add for the byte counters
    function automatic logic [SEQ_W-1:0] sat_add(input logic [SEQ_W-1:0] a,
                                                  input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SEQ_W] ? {SEQ_W{1'b1}} : s[SEQ_W-1:0];
    endfunction

endpackage

/* src/dae_divider.sv */
// ----------------------------------------------------------------------------
// dae_divider
// Restoring divider, one quotient bit per cycle. Quotient bits enter the
// dividend register at the right; done pulses the cycle after the last step.
// ----------------------------------------------------------------------------
module dae_divider
    import dae_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;

    logic [DVS_W:0]   rem_shift;
    logic [DVS_W+1:0] diff;
    logic             ge;

    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign ge        = ~diff[DVS_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DVD_W - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

/* src/dctcp_alpha_estimator_unit.sv */
// ----------------------------------------------------------------------------
// dctcp_alpha_estimator_unit
// Per-connection congestion estimator: byte counting, alpha update once per
// observation window, loss reduction and undo of the congestion window.
// ----------------------------------------------------------------------------
// One request is taken at a time; req_ready stays low until its response has
// been moved into the output register. Start, enter-loss, undo and acks that
// do not end the window pass through S_EXEC and S_DONE; a loss reduction
// multiplies in S_EXEC, then subtracts and floors in S_MUL. An ack ending the
// window runs the bit-serial divider over 42 quotient bits in S_DIV. The
// output register lets a new request be taken while the last response
// still waits for rsp_ready. Configuration writes are always taken.
module dctcp_alpha_estimator_unit
    import dae_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [2:0]            req_type,
    input  logic [SEQ_W-1:0]      ack_seq,
    input  logic [SEQ_W-1:0]      next_send_seq,
    input  logic                  window_update,
    input  logic                  echo_marked,
    input  logic [CWND_W-1:0]     cwnd_in,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [CWND_W-1:0]     window_value,
    output logic [ALPHA_W-1:0]    alpha_now,
    output logic                  window_closed
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [GAIN_W-1:0]  gain_reg;
    logic [ALPHA_W-1:0] init_alpha_reg;
    logic               clamp_reg;
    logic [MSS_W-1:0]   mss_reg;

    // connection state
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [SEQ_W-1:0]   prior_reg, prior_next;
    logic [SEQ_W-1:0]   wend_reg, wend_next;
    logic [SEQ_W-1:0]   total_reg, total_next;
    logic [SEQ_W-1:0]   marked_reg, marked_next;
    logic [CWND_W-1:0]  saved_reg, saved_next;

    // latched request
    logic [2:0]        type_reg;
    logic [SEQ_W-1:0]  ack_reg;
    logic [SEQ_W-1:0]  nxt_reg;
    logic              wupd_reg;
    logic              echo_reg;
    logic [CWND_W-1:0] cwnd_reg;

    logic [CWND_W+ALPHA_W-1:0] prod_reg, prod_next;
    logic [CWND_W-1:0]         wval_reg, wval_next;
    logic                      closed_reg, closed_next;

    logic                      rsp_valid_reg, rsp_valid_next;
    logic [CWND_W-1:0]         out_wval_reg;
    logic [ALPHA_W-1:0]        out_alpha_reg;
    logic                      out_closed_reg;

    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic             div_done;
    logic [DVD_W-1:0] div_quot;

    logic [SEQ_W-1:0]   acked;
    logic [SEQ_W-1:0]   ack_total;
    logic [SEQ_W-1:0]   ack_marked;
    logic [SEQ_W-1:0]   wdist;
    logic [GAIN_W-1:0]  g_eff;
    logic [ALPHA_W-1:0] q_sat;
    logic [ALPHA_W:0]   alpha_sum;
    logic [CWND_W-1:0]  cut;
    logic [CWND_W-1:0]  reduced;
    logic               out_free;

    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == S_IDLE);
    assign out_free  = ~rsp_valid_reg | rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg       <= 4'd4;
            init_alpha_reg <= ALPHA_MAX;
            clamp_reg      <= 1'b1;
            mss_reg        <= 16'd1460;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GAIN_SHIFT:    gain_reg       <= cfg_data[GAIN_W-1:0];
                CFG_INITIAL_ALPHA: init_alpha_reg <= cfg_data[ALPHA_W-1:0];
                CFG_CLAMP_ON_LOSS: clamp_reg      <= cfg_data[0];
                CFG_MSS_BYTES:     mss_reg        <= cfg_data[MSS_W-1:0];
                default:           ;
            endcase
        end
    end

    // ack byte accounting
    always_comb
    begin
        acked = ack_reg - prior_reg;
        if (acked == '0 && !wupd_reg)
            acked = {{(SEQ_W-MSS_W){1'b0}}, mss_reg};
        ack_total  = (acked != '0) ? sat_add(total_reg, acked) : total_reg;
        ack_marked = (acked != '0 && echo_reg) ? sat_add(marked_reg, acked) : marked_reg;
    end

    assign wdist        = ack_reg - wend_reg;
    assign g_eff        = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;
    assign div_dividend = {{(DVD_W-SEQ_W){1'b0}}, ack_marked} << (GAIN_MAX - g_eff);
    assign div_divisor  = (ack_total == '0) ? DVS_W'(1) : ack_total;

    // quotients wider than the alpha field all clamp to all ones
    assign q_sat     = (div_quot[DVD_W-1:ALPHA_W] != '0) ? {ALPHA_W{1'b1}}
                                                          : div_quot[ALPHA_W-1:0];
    assign alpha_sum = {1'b0, alpha_reg} - {1'b0, alpha_reg >> g_eff} + {1'b0, q_sat};

    assign cut     = prod_reg[CWND_W+ALPHA_W-1:ALPHA_W];
    assign reduced = cwnd_reg - cut;

    always_comb
    begin
        state_next     = state_reg;
        alpha_next     = alpha_reg;
        prior_next     = prior_reg;
        wend_next      = wend_reg;
        total_next     = total_reg;
        marked_next    = marked_reg;
        saved_next     = saved_reg;
        prod_next      = prod_reg;
        wval_next      = wval_reg;
        closed_next    = closed_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        div_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                wval_next   = '0;
                closed_next = 1'b0;
                state_next  = S_DONE;
                case (type_reg)
                    REQ_START:
                    begin
                        prior_next  = ack_reg;
                        alpha_next  = (init_alpha_reg > ALPHA_MAX) ? ALPHA_MAX
                                                                   : init_alpha_reg;
                        saved_next  = '0;
                        wend_next   = nxt_reg;
                        total_next  = '0;
                        marked_next = '0;
                    end
                    REQ_ACK:
                    begin
                        total_next  = ack_total;
                        marked_next = ack_marked;
                        if (acked != '0)
                            prior_next = ack_reg;
                        if (!wdist[SEQ_W-1])
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    REQ_LOSS_CUT:
                    begin
                        prod_next  = (CWND_W+ALPHA_W)'(cwnd_reg)
                                   * (CWND_W+ALPHA_W)'(alpha_reg);
                        saved_next = cwnd_reg;
                        state_next = S_MUL;
                    end
                    REQ_ENTER_LOSS:
                    begin
                        if (clamp_reg)
                            alpha_next = ALPHA_MAX;
                    end
                    REQ_UNDO:
                    begin
                        wval_next = (cwnd_reg > saved_reg) ? cwnd_reg : saved_reg;
                    end
                    default: ;
                endcase
            end
            S_MUL:
            begin
                wval_next  = (reduced < CWND_W'(2)) ? CWND_W'(2) : reduced;
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    alpha_next  = (alpha_sum > {1'b0, ALPHA_MAX}) ? ALPHA_MAX
                                                                  : alpha_sum[ALPHA_W-1:0];
                    wend_next   = nxt_reg;
                    total_next  = '0;
                    marked_next = '0;
                    closed_next = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            alpha_reg     <= ALPHA_MAX;
            prior_reg     <= '0;
            wend_reg      <= '0;
            total_reg     <= '0;
            marked_reg    <= '0;
            saved_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            alpha_reg     <= alpha_next;
            prior_reg     <= prior_next;
            wend_reg      <= wend_next;
            total_reg     <= total_next;
            marked_reg    <= marked_next;
            saved_reg     <= saved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        wval_reg    <= wval_next;
        closed_reg  <= closed_next;
        if (state_reg == S_IDLE && req_valid)
        begin
            type_reg <= req_type;
            ack_reg  <= ack_seq;
            nxt_reg  <= next_send_seq;
            wupd_reg <= window_update;
            echo_reg <= echo_marked;
            cwnd_reg <= cwnd_in;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_wval_reg   <= wval_reg;
            out_alpha_reg  <= alpha_reg;
            out_closed_reg <= closed_reg;
        end
    end

    dae_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign rsp_valid     = rsp_valid_reg;
    assign window_value  = out_wval_reg;
    assign alpha_now     = out_alpha_reg;
    assign window_closed = out_closed_reg;

endmodule

/* src/dae_checker.sv */
// ----------------------------------------------------------------------------
// dae_checker
// Port-level checks for the alpha estimator, bound to the top level.
// ----------------------------------------------------------------------------
module dae_checker
    import dae_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [CWND_W-1:0]    window_value,
    input logic [ALPHA_W-1:0]   alpha_now,
    input logic                 window_closed
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(window_value)
                                    && $stable(alpha_now) && $stable(window_closed))
        else $error("response changed while stalled");

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> alpha_now <= ALPHA_MAX)
        else $error("alpha above maximum");

    // a window close comes only from an ack, which reports no window value
    a_closed_no_wval: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && window_closed |-> window_value == '0)
        else $error("window value on a closing ack");

    // one request at a time
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind dctcp_alpha_estimator_unit dae_checker u_dae_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .window_value  (window_value),
    .alpha_now     (alpha_now),
    .window_closed (window_closed)
);
